/* design/bms_rfd_pkg.sv */
package bms_rfd_pkg;

    localparam int MAX_FRAME_BYTES = 14;
    localparam int NUM_CELLS       = 16;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [CNT_W-1:0] MAX_LEN  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] PRE_LEN  = CNT_W'(4);
    localparam logic [CNT_W-1:0] DATA_OFS = CNT_W'(6);

    localparam int NUM_DATA = 4;

    // "+RD," in ascii
    localparam logic [7:0] PREAMBLE [4] = '{8'h2B, 8'h52, 8'h44, 8'h2C};

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE = 2'd1;

    localparam logic DEV_A = 1'b0;
    localparam logic DEV_B = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int OUT_DATA_W = 64;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_LEN,
        ST_BAD_PRE,
        ST_NO_DATA,
        ST_UNHANDLED
    } t_status;

    typedef enum logic [3:0] {
        Q_SOC,
        Q_CAP_REM,
        Q_DESIGN_CAP,
        Q_FULL_CAP,
        Q_VOLT,
        Q_TEMP,
        Q_CURRENT,
        Q_TTE,
        Q_TTF,
        Q_SERIAL,
        Q_CYCLES,
        Q_DATE,
        Q_CELL
    } t_quantity;

    typedef struct packed {
        t_status                    status;
        logic                       dev_type;
        logic [NUM_DATA-1:0][7:0]   data;
    } t_frame;

    typedef struct packed {
        logic               charging;
        logic               value_valid;
        logic signed [24:0] scaled_value;
        logic [15:0]        raw_word;
        logic [3:0]         cell_number;
        t_quantity          quantity;
        logic [7:0]         command_code;
        t_status            status;
    } t_result;

endpackage

/* design/bms_rfd_front.sv */
module bms_rfd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [bms_rfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bms_rfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                                i_full,
    output logic                                o_push,
    output bms_rfd_pkg::t_frame                 o_frame
);
    import bms_rfd_pkg::*;

    function automatic logic [7:0] hex_val(input logic [7:0] ch);
        if (ch <= 8'h39) begin
            return ch - 8'h30;
        end
        return {5'd0, ch[2:0]} + 8'd9;
    endfunction

    logic [7:0]         r_xor_key;
    logic               r_dev_type;
    logic [CNT_W-1:0]   r_count;
    logic               r_pm;
    logic [3:0]         r_hold;
    logic [7:0]         r_data [NUM_DATA];

    logic               accept;
    logic [7:0]         ch;
    logic [7:0]         hv;
    logic               pre_pos;
    logic               n_pm;
    logic               hold_we;
    logic               data_we;
    logic [2:0]         half_pos;
    logic [1:0]         data_idx;
    logic [7:0]         byte_new;
    logic [7:0]         w_data [NUM_DATA];
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   n_minus;
    logic [2:0]         ndata;
    t_status            status;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = accept && s_axis_tlast;

    assign ch      = s_axis_tdata ^ r_xor_key;
    assign hv      = hex_val(ch);
    assign pre_pos = (r_count < PRE_LEN);
    assign n_pm    = r_pm && !(pre_pos && (ch != PREAMBLE[r_count[1:0]]));

    // even positions after the preamble hold the high nibble, odd ones through position 11 finish a byte
    assign hold_we  = !pre_pos && !r_count[0];
    assign data_we  = r_count[0] && (r_count >= CNT_W'(5)) && (r_count <= CNT_W'(11));
    assign half_pos = r_count[3:1] - 3'd2;
    assign data_idx = half_pos[1:0];
    assign byte_new = {r_hold, 4'd0} + hv;

    assign cnt_inc = (r_count == CNT_MAX) ? r_count : r_count + CNT_W'(1);
    assign n_minus = cnt_inc - DATA_OFS;
    assign ndata   = (cnt_inc >= DATA_OFS) ? n_minus[3:1] : 3'd0;

    always_comb begin
        for (int i = 0; i < NUM_DATA; i++) begin
            w_data[i] = (data_we && (data_idx == 2'(i))) ? byte_new : r_data[i];
        end
    end

    always_comb begin
        if ((cnt_inc > MAX_LEN) || cnt_inc[0]) begin
            status = ST_BAD_LEN;
        end else if ((cnt_inc < PRE_LEN) || !n_pm) begin
            status = ST_BAD_PRE;
        end else if (ndata == 3'd0) begin
            status = ST_NO_DATA;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_frame.status   = status;
        o_frame.dev_type = r_dev_type;
        for (int i = 0; i < NUM_DATA; i++) begin
            // bytes beyond the decoded ones read as zero
            o_frame.data[i] = (3'(i) < ndata) ? w_data[i] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor_key  <= '0;
            r_dev_type <= DEV_A;
            r_count    <= '0;
            r_pm       <= 1'b1;
            r_hold     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_XOR_KEY: begin
                        r_xor_key <= i_cfg_wdata;
                    end
                    CFG_DEVICE_TYPE: begin
                        r_dev_type <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (s_axis_tlast) begin
                    r_count <= '0;
                    r_pm    <= 1'b1;
                    r_hold  <= '0;
                end else begin
                    r_count <= cnt_inc;
                    r_pm    <= n_pm;
                    if (hold_we) begin
                        r_hold <= hv[3:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && data_we) begin
            r_data[data_idx] <= byte_new;
        end
    end

endmodule

/* design/bms_rfd_queue.sv */
module bms_rfd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bms_rfd_pkg::t_frame     i_frame,
    output logic                    o_full,
    output logic                    o_valid,
    input  logic                    i_pop,
    output bms_rfd_pkg::t_frame     o_frame
);
    import bms_rfd_pkg::*;

    t_frame             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

/* design/bms_rfd_back.sv */
module bms_rfd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  bms_rfd_pkg::t_frame     i_frame,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output bms_rfd_pkg::t_result    o_result
);
    import bms_rfd_pkg::*;

    // type A command codes
    localparam logic [7:0] A_SOC        = 8'd2;
    localparam logic [7:0] A_CAP_REM    = 8'd4;
    localparam logic [7:0] A_DESIGN_CAP = 8'd60;
    localparam logic [7:0] A_FULL_CAP   = 8'd6;
    localparam logic [7:0] A_VOLT       = 8'd8;
    localparam logic [7:0] A_TEMP       = 8'd12;
    localparam logic [7:0] A_CURRENT    = 8'd16;
    localparam logic [7:0] A_TTE        = 8'd24;
    localparam logic [7:0] A_TTF        = 8'd26;
    localparam logic [7:0] A_SERIAL     = 8'd40;
    localparam logic [7:0] A_CYCLES     = 8'd44;
    localparam logic [7:0] A_DATE       = 8'd72;
    // type B command codes
    localparam logic [7:0] B_SOC        = 8'd13;
    localparam logic [7:0] B_CAP_REM    = 8'd15;
    localparam logic [7:0] B_DESIGN_CAP = 8'd24;
    localparam logic [7:0] B_FULL_CAP   = 8'd16;
    localparam logic [7:0] B_VOLT       = 8'd9;
    localparam logic [7:0] B_TEMP       = 8'd8;
    localparam logic [7:0] B_CURRENT    = 8'd10;
    localparam logic [7:0] B_TTE        = 8'd18;
    localparam logic [7:0] B_TTF        = 8'd19;
    localparam logic [7:0] B_SERIAL     = 8'd28;
    localparam logic [7:0] B_CYCLES     = 8'd23;
    localparam logic [7:0] B_DATE       = 8'd27;
    localparam logic [7:0] B_CELL_LO    = 8'd47;
    localparam logic [7:0] B_CELL_HI    = 8'd62;

    localparam logic [15:0]        TIME_INVALID = 16'hFFFF;
    localparam logic signed [24:0] TEMP_OFFSET  = 25'sd27315;
    localparam logic [7:0]         MUL_ONE      = 8'd1;
    localparam logic [7:0]         MUL_TEN      = 8'd10;
    localparam logic [7:0]         MUL_SIXTY    = 8'd60;

    t_result            r_result;
    logic               r_valid;

    logic [7:0]         cmd;
    logic [15:0]        raw;
    logic [7:0]         cell_diff;
    logic               known;
    t_quantity          qty;
    logic [3:0]         cell_idx;
    logic               sign_ext;
    logic [15:0]        mul_src;
    logic [7:0]         mul_k;
    logic signed [16:0] mul_a;
    logic signed [8:0]  mul_b;
    logic signed [25:0] prod;
    logic signed [24:0] val;
    logic               time_bad;
    t_result            res;

    assign cmd       = i_frame.data[0];
    assign raw       = {i_frame.data[2], i_frame.data[1]};
    assign cell_diff = B_CELL_HI - cmd;

    always_comb begin
        known    = 1'b1;
        qty      = Q_SOC;
        cell_idx = 4'd0;
        if (i_frame.dev_type == DEV_A) begin
            case (cmd)
                A_SOC:        qty = Q_SOC;
                A_CAP_REM:    qty = Q_CAP_REM;
                A_DESIGN_CAP: qty = Q_DESIGN_CAP;
                A_FULL_CAP:   qty = Q_FULL_CAP;
                A_VOLT:       qty = Q_VOLT;
                A_TEMP:       qty = Q_TEMP;
                A_CURRENT:    qty = Q_CURRENT;
                A_TTE:        qty = Q_TTE;
                A_TTF:        qty = Q_TTF;
                A_SERIAL:     qty = Q_SERIAL;
                A_CYCLES:     qty = Q_CYCLES;
                A_DATE:       qty = Q_DATE;
                default:      known = 1'b0;
            endcase
        end else begin
            case (cmd)
                B_SOC:        qty = Q_SOC;
                B_CAP_REM:    qty = Q_CAP_REM;
                B_DESIGN_CAP: qty = Q_DESIGN_CAP;
                B_FULL_CAP:   qty = Q_FULL_CAP;
                B_VOLT:       qty = Q_VOLT;
                B_TEMP:       qty = Q_TEMP;
                B_CURRENT:    qty = Q_CURRENT;
                B_TTE:        qty = Q_TTE;
                B_TTF:        qty = Q_TTF;
                B_SERIAL:     qty = Q_SERIAL;
                B_CYCLES:     qty = Q_CYCLES;
                B_DATE:       qty = Q_DATE;
                default: begin
                    // cell voltages count down from the top code
                    if ((cmd >= B_CELL_LO) && (cmd <= B_CELL_HI)
                        && (cell_diff < 8'(NUM_CELLS))) begin
                        qty      = Q_CELL;
                        cell_idx = cell_diff[3:0];
                    end else begin
                        known = 1'b0;
                    end
                end
            endcase
        end
    end

    // one shared multiplier: operand and factor picked per quantity
    always_comb begin
        sign_ext = 1'b0;
        mul_src  = raw;
        mul_k    = MUL_ONE;
        case (qty)
            Q_SOC: begin
                mul_src = {8'd0, i_frame.data[1]};
            end
            Q_CAP_REM, Q_DESIGN_CAP, Q_FULL_CAP: begin
                mul_k = i_frame.data[3];
            end
            Q_TEMP: begin
                mul_k = MUL_TEN;
            end
            Q_CURRENT: begin
                sign_ext = 1'b1;
                if (i_frame.dev_type == DEV_A) begin
                    mul_k = MUL_TEN;
                end else if (i_frame.data[3] != 8'd0) begin
                    mul_k = i_frame.data[3];
                end
            end
            Q_TTE, Q_TTF: begin
                mul_k = MUL_SIXTY;
            end
            default: begin
            end
        endcase
    end

    assign mul_a    = $signed({sign_ext & mul_src[15], mul_src});
    assign mul_b    = $signed({1'b0, mul_k});
    assign prod     = mul_a * mul_b;
    assign time_bad = ((qty == Q_TTE) || (qty == Q_TTF)) && (raw == TIME_INVALID);
    assign val      = (qty == Q_TEMP) ? prod[24:0] - TEMP_OFFSET : prod[24:0];

    always_comb begin
        res = '0;
        res.status = i_frame.status;
        if (i_frame.status == ST_OK) begin
            res.command_code = cmd;
            res.raw_word     = raw;
            if (!known) begin
                res.status = ST_UNHANDLED;
            end else begin
                res.quantity     = qty;
                res.cell_number  = cell_idx;
                res.value_valid  = !time_bad;
                res.scaled_value = time_bad ? 25'sd0 : val;
                res.charging     = (qty == Q_CURRENT) && (val > 25'sd0);
            end
        end
    end

    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= res;
        end
    end

endmodule

/* design/bms_response_frame_decoder_core.sv */
// a frame's result passes through the frame queue and then the result register before it is presented
// throughput: one byte per cycle unless the queue is full; frames of any length, down to one byte, follow back to back
// a two-entry frame queue sits between the byte front end and the result stage, so the
// input stalls only once two finished frames wait behind a result that is not taken
// reset (synchronous, active low) empties the queue and output, restarts the frame and
// clears xor key and device type to zero
module bms_response_frame_decoder_core (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                                  s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // [2:0] status, [10:3] command_code, [14:11] quantity, [18:15] cell_number,
    // [34:19] raw_word, [59:35] scaled_value, [60] value_valid, [61] charging, [63:62] zero
    output logic [bms_rfd_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  logic                                        i_cfg_we,
    input  logic [bms_rfd_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [bms_rfd_pkg::CFG_DATA_W-1:0]          i_cfg_wdata
);
    import bms_rfd_pkg::*;

    logic       push;
    logic       full;
    logic       q_valid;
    logic       pop;
    t_frame     front_frame;
    t_frame     head_frame;
    t_result    result;

    bms_rfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_full         (full),
        .o_push         (push),
        .o_frame        (front_frame)
    );

    bms_rfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_frame    (front_frame),
        .o_full     (full),
        .o_valid    (q_valid),
        .i_pop      (pop),
        .o_frame    (head_frame)
    );

    bms_rfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_frame    (head_frame),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), result};

    // a finished frame is always waiting in the queue the cycle after its last byte
    a_frame_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> q_valid)
        else $error("finished frame missing from queue");

    a_bad_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (result.status != ST_OK)
        |-> !result.value_valid && (result.scaled_value == '0) && !result.charging)
        else $error("failed frame carries a value");

    a_charging_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && result.charging |-> (result.quantity == Q_CURRENT))
        else $error("charging flag on non-current result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output or queue not empty after reset");

endmodule

/* dv/bms_response_frame_decoder_core_tb.sv */
module bms_response_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_rfd_pkg::*;

    localparam int N_DIR          = 28;
    localparam int N_RANDOM_BYTES = 1500;
    localparam int PHASE_BYTES    = 300;
    localparam int RUN_LIMIT      = 400000;
    localparam int ZERO_C_CENTI   = 27315;
    localparam int MAX_SHOWN      = 10;

    // command codes per device type, indexed by quantity
    localparam logic [7:0] A_CMD [12] = '{8'd2, 8'd4, 8'd60, 8'd6, 8'd8, 8'd12,
                                         8'd16, 8'd24, 8'd26, 8'd40, 8'd44, 8'd72};
    localparam logic [7:0] B_CMD [12] = '{8'd13, 8'd15, 8'd24, 8'd16, 8'd9, 8'd8,
                                         8'd10, 8'd18, 8'd19, 8'd28, 8'd23, 8'd27};
    localparam logic [7:0] CELL_CMD_TOP = 8'd62;
    localparam logic [7:0] CELL_CMD_BOT = 8'd47;

    typedef struct packed {
        logic [8*22-1:0] text;    // ascii, last character in the low byte
        logic [7:0]      key;
        logic            dev;
        logic            typed;
        t_result         res;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // [7:0] rx_byte
    logic [7:0]                    s_axis_tdata = 8'h00;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [2:0] status, [10:3] command_code, [14:11] quantity, [18:15] cell_number,
    // [34:19] raw_word, [59:35] scaled_value, [60] value_valid, [61] charging
    logic [OUT_DATA_W-1:0]         m_axis_tdata;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_wdata = '0;

    // decoder state as the testbench sees it
    logic [7:0]       cfg_key = 8'h00;
    logic             cfg_dev = DEV_A;
    logic [CNT_W-1:0] fr_count = '0;
    logic             fr_pre_ok = 1'b1;
    logic [3:0]       fr_hold = 4'h0;
    logic [7:0]       fr_data [5] = '{default: 8'h00};

    t_result    results_due [$];
    logic [7:0] frame_buf [$];
    t_dir_row   dir_tab [N_DIR];
    int         n_errors = 0;
    int         bytes_sent = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    bms_response_frame_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("FAIL bms_response_frame_decoder_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 27);
    end

    // anything above '9' maps to its low three bits plus nine
    function automatic logic [7:0] ascii_nibble(input logic [7:0] c);
        if (c <= 8'h39)
            return c - 8'h30;
        return {5'b0, c[2:0]} + 8'd9;
    endfunction

    function automatic t_result typed_res(input t_status st, input logic [7:0] cmd,
                                          input t_quantity qty, input logic [15:0] raw,
                                          input logic signed [24:0] val, input logic ok);
        t_result r;
        r = '0;
        r.status       = st;
        r.command_code = cmd;
        r.quantity     = qty;
        r.raw_word     = raw;
        r.scaled_value = val;
        r.value_valid  = ok;
        return r;
    endfunction

    // advances the frame state by one byte, returns 1 with the frame result on the last one
    function automatic bit decode_rx_byte(input logic [7:0] rx, input logic lst,
                                          output t_result res);
        logic [7:0]       c;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] n;
        logic [7:0]       d [4];
        logic [15:0]      raw;
        logic             pm;
        logic             found;
        t_quantity        qty;
        t_status          st;
        logic [3:0]       cell_idx;
        int               ndata;
        int               val;
        int               sraw;
        int               i;
        c = rx ^ cfg_key;
        pos = fr_count;
        res = '0;
        if (pos < PRE_LEN) begin
            if (c != PREAMBLE[pos[1:0]])
                fr_pre_ok = 1'b0;
        end else if (pos != CNT_MAX) begin
            if (!pos[0])
                fr_hold = 4'(ascii_nibble(c));
            else
                fr_data[3'((pos - CNT_W'(5)) >> 1)] = {fr_hold, 4'h0} + ascii_nibble(c);
        end
        if (fr_count != CNT_MAX)
            fr_count = fr_count + 1'b1;
        if (!lst)
            return 1'b0;

        n = fr_count;
        pm = fr_pre_ok;
        fr_count = '0;
        fr_pre_ok = 1'b1;
        fr_hold = 4'h0;
        ndata = (n >= DATA_OFS) ? int'(n - DATA_OFS) / 2 : 0;
        if (ndata > NUM_DATA)
            ndata = NUM_DATA;
        for (i = 0; i < NUM_DATA; i++)
            d[i] = (i < ndata) ? fr_data[i] : 8'h00;
        raw = {d[2], d[1]};

        if (n > MAX_LEN || n[0])
            st = ST_BAD_LEN;
        else if (n < PRE_LEN || !pm)
            st = ST_BAD_PRE;
        else if (ndata == 0)
            st = ST_NO_DATA;
        else
            st = ST_OK;

        found = 1'b0;
        qty = Q_SOC;
        cell_idx = 4'h0;
        if (st == ST_OK) begin
            for (i = 0; i < 12; i++) begin
                if (d[0] == ((cfg_dev == DEV_A) ? A_CMD[i] : B_CMD[i])) begin
                    found = 1'b1;
                    qty = t_quantity'(i);
                end
            end
            if (!found && cfg_dev == DEV_B && d[0] >= CELL_CMD_BOT && d[0] <= CELL_CMD_TOP
                    && int'(CELL_CMD_TOP - d[0]) < NUM_CELLS) begin
                found = 1'b1;
                qty = Q_CELL;
                cell_idx = 4'(CELL_CMD_TOP - d[0]);
            end
            if (!found)
                st = ST_UNHANDLED;
        end

        res.status = st;
        if (st == ST_OK || st == ST_UNHANDLED) begin
            res.command_code = d[0];
            res.raw_word = raw;
        end
        if (st == ST_OK) begin
            sraw = $signed(raw);
            res.value_valid = 1'b1;
            case (qty)
                Q_SOC: val = int'(d[1]);
                Q_CAP_REM, Q_DESIGN_CAP, Q_FULL_CAP: val = int'(raw) * int'(d[3]);
                Q_TEMP: val = int'(raw) * 10 - ZERO_C_CENTI;
                Q_CURRENT: begin
                    if (cfg_dev == DEV_A)
                        val = sraw * 10;
                    else
                        val = sraw * ((d[3] != 8'h00) ? int'(d[3]) : 1);
                    res.charging = (val > 0);
                end
                Q_TTE, Q_TTF: begin
                    // all ones means the gauge has no estimate
                    if (raw == 16'hFFFF) begin
                        val = 0;
                        res.value_valid = 1'b0;
                    end else begin
                        val = int'(raw) * 60;
                    end
                end
                default: val = int'(raw);
            endcase
            res.quantity = qty;
            res.cell_number = cell_idx;
            res.scaled_value = val[24:0];
        end
        return 1'b1;
    endfunction

    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        got = t_result'(m_axis_tdata[61:0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                if (n_errors < MAX_SHOWN)
                    $display("%0t: result with none pending: st=%0d cmd=%h raw=%h",
                             $realtime, got.status, got.command_code, got.raw_word);
                n_errors++;
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.command_code !== want.command_code
                        || got.quantity !== want.quantity
                        || got.cell_number !== want.cell_number
                        || got.raw_word !== want.raw_word
                        || got.scaled_value !== want.scaled_value
                        || got.value_valid !== want.value_valid
                        || got.charging !== want.charging
                        || m_axis_tdata[63:62] !== 2'b00) begin
                    if (n_errors < MAX_SHOWN) begin
                        $display({"%0t: got  st=%0d cmd=%h q=%0d cell=%0d raw=%h val=%0d",
                                  " v=%b c=%b pad=%b"},
                                 $realtime, got.status, got.command_code, got.quantity,
                                 got.cell_number, got.raw_word, got.scaled_value,
                                 got.value_valid, got.charging, m_axis_tdata[63:62]);
                        $display("      want st=%0d cmd=%h q=%0d cell=%0d raw=%h val=%0d v=%b c=%b",
                                 want.status, want.command_code, want.quantity,
                                 want.cell_number, want.raw_word, want.scaled_value,
                                 want.value_valid, want.charging);
                    end
                    n_errors++;
                end
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic lst, input logic typed,
                            input t_result typed_val);
        t_result pred;
        logic    acc;
        while (!calm && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        acc = 1'b0;
        while (!acc) begin
            @(negedge i_clk);
            acc = s_axis_tready;
            if (acc) begin
                if (decode_rx_byte(b, lst, pred))
                    results_due.insert(results_due.size(), typed ? typed_val : pred);
            end
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_XOR_KEY)
            cfg_key = val;
        else if (idx == CFG_DEVICE_TYPE)
            cfg_dev = val[0];
    endtask

    task automatic apply_cfg(input logic [7:0] key, input logic dev);
        drain();
        reg_write(CFG_XOR_KEY, key);
        reg_write(CFG_DEVICE_TYPE, {7'($urandom), dev});
        // indexes past the register list must leave both registers alone
        reg_write(CFG_IDX_W'($urandom_range(2, 3)), 8'($urandom));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if ($urandom_range(19) == 0)
            return 8'($urandom);
        if (v < 4'd10)
            return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + (v - 4'd10);
    endfunction

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 8'($urandom);
        if (cfg_dev == DEV_A)
            return A_CMD[4'($urandom_range(11))];
        if (r < 35)
            return CELL_CMD_TOP - 8'($urandom_range(NUM_CELLS - 1));
        return B_CMD[4'($urandom_range(11))];
    endfunction

    task automatic random_frame();
        int         kind;
        int         npairs;
        int         i;
        logic [7:0] data [4];
        frame_buf.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) frame_buf.insert(frame_buf.size(), 8'($urandom));
        end else begin
            for (i = 0; i < 4; i++)
                frame_buf.insert(frame_buf.size(), PREAMBLE[i]);
            npairs = ($urandom_range(9) < 2) ? $urandom_range(2) : $urandom_range(3, 4);
            data[0] = pick_cmd();
            for (i = 1; i < 4; i++)
                data[i] = 8'($urandom);
            if ($urandom_range(9) == 0) begin
                data[1] = 8'hFF;
                data[2] = 8'hFF;
            end
            for (i = 0; i < npairs; i++) begin
                frame_buf.insert(frame_buf.size(), hex_char(data[i][7:4]));
                frame_buf.insert(frame_buf.size(), hex_char(data[i][3:0]));
            end
            // two trailing characters that do not become data unless extra characters follow them
            frame_buf.insert(frame_buf.size(), hex_char(4'($urandom)));
            frame_buf.insert(frame_buf.size(), hex_char(4'($urandom)));
            if (kind < 14) begin
                i = $urandom_range(3);
                frame_buf[i] = frame_buf[i] ^ 8'(1 << $urandom_range(7));
            end else if (kind < 20) begin
                repeat ($urandom_range(1, 3))
                    frame_buf.insert(frame_buf.size(), hex_char(4'($urandom)));
            end
        end
        for (i = 0; i < frame_buf.size(); i++) begin
            put_byte(frame_buf[i] ^ cfg_key, i == frame_buf.size() - 1, 1'b0, '0);
            bytes_sent++;
        end
    endtask

    initial begin : main
        t_dir_row row;
        int       r;
        int       i;
        int       len;
        int       phase;
        int       target;

        dir_tab[0]  = '{"+RD,026400ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_OK, 8'h02, Q_SOC, 16'h0064, 25'sd100, 1'b1)};
        dir_tab[1]  = '{"+RD,04E803FAZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[2]  = '{"+RD,3C10270AZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[3]  = '{"+RD,06FFFFFFZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[4]  = '{"+RD,08d20f00ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[5]  = '{"+RD,0C000000ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[6]  = '{"+RD,1018FC00ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[7]  = '{"+RD,18FFFF00ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_OK, 8'h18, Q_TTE, 16'hFFFF, 25'sd0, 1'b0)};
        dir_tab[8]  = '{"+RD,1A2C0100ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[9]  = '{"+RD,28341200ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[10] = '{"+RD,2CFF0000ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[11] = '{"+RD,48AB5C00ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[12] = '{"+RD,99341200ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_UNHANDLED, 8'h99, Q_SOC, 16'h1234, 25'sd0, 1'b0)};
        dir_tab[13] = '{"+RD,02640", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_BAD_LEN, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[14] = '{"+RD,0264000000000000ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_BAD_LEN, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[15] = '{"+RD,0264000000ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_BAD_LEN, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[16] = '{"+R", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_BAD_PRE, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[17] = '{"+RX,026400ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_BAD_PRE, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[18] = '{"+RD,", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_NO_DATA, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[19] = '{"+RD,ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_NO_DATA, 8'h00, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        // one data byte only: the raw word reads as zero
        dir_tab[20] = '{"+RD,02ZZ", 8'h00, DEV_A, 1'b1,
                        typed_res(ST_OK, 8'h02, Q_SOC, 16'h0000, 25'sd0, 1'b1)};
        dir_tab[21] = '{"+RD,:2gz!~ZZ", 8'h00, DEV_A, 1'b0, '0};
        dir_tab[22] = '{"+RD,2FA00F00ZZ", 8'h5A, DEV_B, 1'b0, '0};
        dir_tab[23] = '{"+RD,3EE80C00ZZ", 8'h5A, DEV_B, 1'b0, '0};
        dir_tab[24] = '{"+RD,0A9CFF03ZZ", 8'hFF, DEV_B, 1'b0, '0};
        dir_tab[25] = '{"+RD,0A6400ZZ", 8'hFF, DEV_B, 1'b0, '0};
        dir_tab[26] = '{"+RD,2E000000ZZ", 8'hFF, DEV_B, 1'b1,
                        typed_res(ST_UNHANDLED, 8'h2E, Q_SOC, 16'h0000, 25'sd0, 1'b0)};
        dir_tab[27] = '{"+RD,13FFFF00ZZ", 8'hFF, DEV_B, 1'b0, '0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_DIR; r++) begin
            row = dir_tab[r];
            if (row.key != cfg_key || row.dev != cfg_dev)
                apply_cfg(row.key, row.dev);
            len = 0;
            while (len < 22 && row.text[8*len +: 8] != 8'h00)
                len++;
            for (i = 0; i < len; i++)
                put_byte(row.text[8*(len-1-i) +: 8] ^ cfg_key, i == len - 1, row.typed, row.res);
        end

        phase = 0;
        while (bytes_sent < N_RANDOM_BYTES) begin
            case (phase)
                0:       apply_cfg(8'h00, DEV_A);
                1:       apply_cfg(8'hFF, DEV_B);
                default: apply_cfg(8'($urandom), 1'($urandom));
            endcase
            // one phase runs with both sides streaming at full rate
            calm <= (phase == 2);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target && bytes_sent < N_RANDOM_BYTES)
                random_frame();
            phase++;
        end
        calm <= 1'b0;
        drain();

        if (n_errors == 0)
            $display("PASS bms_response_frame_decoder_core");
        else
            $display("FAIL bms_response_frame_decoder_core");
        $finish;
    end

endmodule

/* sim.f */
design/bms_rfd_pkg.sv
design/bms_rfd_front.sv
design/bms_rfd_queue.sv
design/bms_rfd_back.sv
design/bms_response_frame_decoder_core.sv
dv/bms_response_frame_decoder_core_tb.sv
